>>> design/pph_pkg.sv
// Shared types and constants for the PES packet header parser.
// Used by the channel interfaces, the parser stage, the result queue and the top level.
`default_nettype none

package pph_pkg;

   localparam int TS_W    = 33;
   localparam int SHIFT_W = 40;
   localparam int SEEN_W  = 17;
   localparam int Q_DEPTH = 4;
   localparam int QA_W    = $clog2(Q_DEPTH);

   localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

   localparam logic [7:0] SID_AUDIO_MASK  = 8'hE0;
   localparam logic [7:0] SID_AUDIO       = 8'hC0;
   localparam logic [7:0] SID_VIDEO_MASK  = 8'hF0;
   localparam logic [7:0] SID_VIDEO       = 8'hE0;
   localparam logic [7:0] SID_PRIVATE_ONE = 8'hBD;
   localparam logic [7:0] PREFIX_ZERO     = 8'h00;
   localparam logic [7:0] PREFIX_ONE      = 8'h01;
   localparam logic [1:0] MARKER_BITS     = 2'b10;
   localparam logic [1:0] TF_PTS_ONLY     = 2'b10;
   localparam logic [1:0] TF_PTS_DTS      = 2'b11;
   localparam logic [3:0] TS_PREFIX_DTS   = 4'h1;

   typedef enum logic [1:0] {
      KIND_HDR = 2'd0,
      KIND_PAY = 2'd1,
      KIND_END = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ERROR = 2'd1,
      ST_TRUNC = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FIXED,
      PH_EXTRA,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
      logic       unit_start;
   } req_type;

   typedef struct packed {
      kind_type        kind;
      logic [7:0]      stream_id;
      logic [TS_W-1:0] pts;
      logic [TS_W-1:0] dts;
      logic            pts_valid;
      logic            dts_valid;
      logic            align_flag;
      logic            size_known;
      logic [15:0]     payload_size;
      logic [7:0]      payload_byte;
      status_type      status;
      logic            last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

>>> design/pph_if.sv
// Channel interfaces of the PES packet header parser: byte requests,
// result records and the configuration write. Depends on pph_pkg.
`default_nettype none

interface pph_req_if;
   import pph_pkg::*;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data;
   logic       unit_start;
   modport source (output valid, op, data, unit_start, input ready);
   modport sink (input valid, op, data, unit_start, output ready);
endinterface

interface pph_rsp_if;
   import pph_pkg::*;
   logic            valid;
   logic            ready;
   logic [1:0]      kind;
   logic [7:0]      stream_id;
   logic [TS_W-1:0] pts;
   logic [TS_W-1:0] dts;
   logic            pts_valid;
   logic            dts_valid;
   logic            align_flag;
   logic            size_known;
   logic [15:0]     payload_size;
   logic [7:0]      payload_byte;
   logic [1:0]      status;
   logic            last;
   modport source (output valid, kind, stream_id, pts, dts, pts_valid, dts_valid,
                   align_flag, size_known, payload_size, payload_byte, status, last,
                   input ready);
   modport sink (input valid, kind, stream_id, pts, dts, pts_valid, dts_valid,
                 align_flag, size_known, payload_size, payload_byte, status, last,
                 output ready);
endinterface

interface pph_csr_if;
   logic valid;
   logic ready;
   logic accept_private_one;
   modport source (output valid, accept_private_one, input ready);
   modport sink (input valid, accept_private_one, output ready);
endinterface

`default_nettype wire

>>> design/pph_parser.sv
// Input stage register, parser state and per-item record generation.
// Depends on pph_pkg; feeds pph_out_queue with up to two records per item.
`default_nettype none

module pph_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  pph_pkg::req_type   req_item,
   output logic               req_ready,
   input  logic               cfg_we,
   input  logic               cfg_data,
   input  logic               space_ok,
   output pph_pkg::push_type  push
);
   import pph_pkg::*;

   logic                stage_valid_ff, stage_valid_in;
   req_type             stage_ff;
   logic                advance;
   logic                accept_private_one_ff;

   phase_type           phase_ff, phase_in;
   logic [SEEN_W-1:0]   bytes_seen_ff, bytes_seen_in;
   logic [15:0]         packet_length_ff, packet_length_in;
   logic [7:0]          current_stream_ff, current_stream_in;
   logic [1:0]          time_flags_ff, time_flags_in;
   logic                alignment_seen_ff, alignment_seen_in;
   logic [7:0]          header_extra_length_ff, header_extra_length_in;
   logic [SHIFT_W-1:0]  pts_shift_ff, pts_shift_in;
   logic [SHIFT_W-1:0]  dts_shift_ff, dts_shift_in;

   logic                close_v;
   status_type          close_st;
   logic                main0_v, main1_v;
   result_type          main0_r, main1_r;

   function automatic result_type end_rec(logic [7:0] sid, status_type st);
      result_type r;
      r           = '0;
      r.kind      = KIND_END;
      r.stream_id = sid;
      r.status    = st;
      r.last      = 1'b1;
      return r;
   endfunction

   function automatic result_type pay_rec(logic [7:0] sid, logic [7:0] pb);
      result_type r;
      r              = '0;
      r.kind         = KIND_PAY;
      r.stream_id    = sid;
      r.payload_byte = pb;
      return r;
   endfunction

   function automatic logic ts_ok(logic [SHIFT_W-1:0] s, logic [3:0] prefix);
      return (s[39:36] == prefix) && s[0] && s[16] && s[32];
   endfunction

   function automatic logic [TS_W-1:0] ts_value(logic [SHIFT_W-1:0] s);
      return {s[35:33], s[31:17], s[15:1]};
   endfunction

   function automatic logic [15:0] es_size(logic [15:0] pl, logic [7:0] hel);
      if (pl == '0) begin
         return '0;
      end
      return pl - 16'd3 - {8'd0, hel};
   endfunction

   function automatic result_type hdr_rec(logic [7:0] sid, logic [1:0] tf, logic al,
                                          logic [15:0] pl, logic [7:0] hel,
                                          logic [SHIFT_W-1:0] ps,
                                          logic [SHIFT_W-1:0] ds);
      result_type r;
      r              = '0;
      r.kind         = KIND_HDR;
      r.stream_id    = sid;
      r.pts_valid    = tf[1];
      r.dts_valid    = (tf == TF_PTS_DTS);
      r.pts          = tf[1] ? ts_value(ps) : '0;
      r.dts          = (tf == TF_PTS_DTS) ? ts_value(ds) : '0;
      r.align_flag   = al;
      r.size_known   = (pl != '0);
      r.payload_size = es_size(pl, hel);
      return r;
   endfunction

   assign advance   = stage_valid_ff && space_ok;
   assign req_ready = !stage_valid_ff || advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (phase_ff == PH_PAYLOAD) begin
         close_st = (packet_length_ff != '0) ? ST_TRUNC : ST_OK;
      end else if (bytes_seen_ff < SEEN_W'(6) || packet_length_ff != '0) begin
         close_st = ST_TRUNC;
      end else begin
         close_st = ST_ERROR;
      end
   end

   always_comb begin
      logic [SEEN_W-1:0] i;
      logic [7:0]        b;
      logic [7:0]        need;
      logic              bad;
      logic              wanted;
      phase_type         cur_phase;
      i         = '0;
      b         = stage_ff.data;
      need      = '0;
      bad       = 1'b0;
      wanted    = 1'b0;
      cur_phase = PH_IDLE;

      phase_in               = phase_ff;
      bytes_seen_in          = bytes_seen_ff;
      packet_length_in       = packet_length_ff;
      current_stream_in      = current_stream_ff;
      time_flags_in          = time_flags_ff;
      alignment_seen_in      = alignment_seen_ff;
      header_extra_length_in = header_extra_length_ff;
      pts_shift_in           = pts_shift_ff;
      dts_shift_in           = dts_shift_ff;
      close_v                = 1'b0;
      main0_v                = 1'b0;
      main1_v                = 1'b0;
      main0_r                = end_rec(current_stream_ff, ST_OK);
      main1_r                = end_rec(current_stream_ff, ST_OK);

      if (stage_ff.op || stage_ff.unit_start) begin
         close_v = (phase_ff != PH_IDLE);
         if (close_v) begin
            phase_in = PH_IDLE;
         end
      end

      if (!stage_ff.op) begin
         if (stage_ff.unit_start) begin
            phase_in               = PH_FIXED;
            bytes_seen_in          = '0;
            packet_length_in       = '0;
            current_stream_in      = '0;
            time_flags_in          = '0;
            alignment_seen_in      = 1'b0;
            header_extra_length_in = '0;
            pts_shift_in           = '0;
            dts_shift_in           = '0;
         end
         cur_phase = phase_in;
         i         = bytes_seen_in;
         if (cur_phase != PH_IDLE && bytes_seen_in != SEEN_MAX) begin
            bytes_seen_in = bytes_seen_in + SEEN_W'(1);
         end
         unique case (cur_phase)
            PH_IDLE: begin
            end
            PH_FIXED: begin
               if (i < SEEN_W'(8)) begin
                  unique case (i[2:0])
                     3'd0, 3'd1: begin
                        if (b != PREFIX_ZERO) begin
                           main0_v  = 1'b1;
                           main0_r  = end_rec(current_stream_in, ST_ERROR);
                           phase_in = PH_IDLE;
                        end
                     end
                     3'd2: begin
                        if (b != PREFIX_ONE) begin
                           main0_v  = 1'b1;
                           main0_r  = end_rec(current_stream_in, ST_ERROR);
                           phase_in = PH_IDLE;
                        end
                     end
                     3'd3: begin
                        current_stream_in = b;
                        wanted = ((b & SID_AUDIO_MASK) == SID_AUDIO)
                              || ((b & SID_VIDEO_MASK) == SID_VIDEO)
                              || (b == SID_PRIVATE_ONE && accept_private_one_ff);
                        if (!wanted) begin
                           phase_in = PH_IDLE;
                        end
                     end
                     3'd4: begin
                        packet_length_in = {b, 8'd0};
                     end
                     3'd5: begin
                        packet_length_in = {packet_length_ff[15:8], b};
                     end
                     3'd6: begin
                        if (b[7:6] != MARKER_BITS) begin
                           main0_v  = 1'b1;
                           main0_r  = end_rec(current_stream_in, ST_ERROR);
                           phase_in = PH_IDLE;
                        end else begin
                           alignment_seen_in = b[2];
                        end
                     end
                     default: begin
                        time_flags_in = b[7:6];
                     end
                  endcase
               end else begin
                  if (time_flags_in == TF_PTS_ONLY) begin
                     need = 8'd5;
                  end else if (time_flags_in == TF_PTS_DTS) begin
                     need = 8'd10;
                  end
                  header_extra_length_in = b;
                  if (b < need || (packet_length_in != '0
                                   && packet_length_in < 16'd3 + {8'd0, b})) begin
                     main0_v  = 1'b1;
                     main0_r  = end_rec(current_stream_in, ST_ERROR);
                     phase_in = PH_IDLE;
                  end else if (b != '0) begin
                     phase_in = PH_EXTRA;
                  end else begin
                     main0_v  = 1'b1;
                     main0_r  = hdr_rec(current_stream_in, time_flags_in,
                                        alignment_seen_in, packet_length_in,
                                        header_extra_length_in, pts_shift_in,
                                        dts_shift_in);
                     phase_in = PH_PAYLOAD;
                     if (packet_length_in != '0
                         && es_size(packet_length_in, header_extra_length_in) == '0) begin
                        main1_v  = 1'b1;
                        main1_r  = end_rec(current_stream_in, ST_OK);
                        phase_in = PH_IDLE;
                     end
                  end
               end
            end
            PH_EXTRA: begin
               if (time_flags_in[1] && i < SEEN_W'(14)) begin
                  pts_shift_in = {pts_shift_ff[SHIFT_W-9:0], b};
                  bad = (i == SEEN_W'(13)) && !ts_ok(pts_shift_in, {2'b00, time_flags_in});
               end else if (time_flags_in == TF_PTS_DTS && i < SEEN_W'(19)) begin
                  dts_shift_in = {dts_shift_ff[SHIFT_W-9:0], b};
                  bad = (i == SEEN_W'(18)) && !ts_ok(dts_shift_in, TS_PREFIX_DTS);
               end
               if (bad) begin
                  main0_v  = 1'b1;
                  main0_r  = end_rec(current_stream_in, ST_ERROR);
                  phase_in = PH_IDLE;
               end else if (i >= SEEN_W'(header_extra_length_in) + SEEN_W'(8)) begin
                  main0_v  = 1'b1;
                  main0_r  = hdr_rec(current_stream_in, time_flags_in,
                                     alignment_seen_in, packet_length_in,
                                     header_extra_length_in, pts_shift_in,
                                     dts_shift_in);
                  phase_in = PH_PAYLOAD;
                  if (packet_length_in != '0
                      && es_size(packet_length_in, header_extra_length_in) == '0) begin
                     main1_v  = 1'b1;
                     main1_r  = end_rec(current_stream_in, ST_OK);
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_PAYLOAD: begin
               main0_v = 1'b1;
               main0_r = pay_rec(current_stream_in, b);
               if (packet_length_in != '0
                   && i >= SEEN_W'(packet_length_in) + SEEN_W'(5)) begin
                  main1_v  = 1'b1;
                  main1_r  = end_rec(current_stream_in, ST_OK);
                  phase_in = PH_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      push.count  = '0;
      push.first  = main0_r;
      push.second = main1_r;
      if (close_v) begin
         push.first  = end_rec(current_stream_ff, close_st);
         push.second = main0_r;
      end
      if (advance) begin
         push.count = {1'b0, close_v} + {1'b0, main0_v} + {1'b0, main1_v};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff         <= 1'b0;
         accept_private_one_ff  <= 1'b1;
         phase_ff               <= PH_IDLE;
         bytes_seen_ff          <= '0;
         packet_length_ff       <= '0;
         current_stream_ff      <= '0;
         time_flags_ff          <= '0;
         alignment_seen_ff      <= 1'b0;
         header_extra_length_ff <= '0;
         pts_shift_ff           <= '0;
         dts_shift_ff           <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (cfg_we) begin
            accept_private_one_ff <= cfg_data;
         end
         if (advance) begin
            phase_ff               <= phase_in;
            bytes_seen_ff          <= bytes_seen_in;
            packet_length_ff       <= packet_length_in;
            current_stream_ff      <= current_stream_in;
            time_flags_ff          <= time_flags_in;
            alignment_seen_ff      <= alignment_seen_in;
            header_extra_length_ff <= header_extra_length_in;
            pts_shift_ff           <= pts_shift_in;
            dts_shift_ff           <= dts_shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= req_item;
      end
   end

`ifndef SYNTH
   a_pair_closes: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |=> phase_ff == PH_IDLE)
      else $error("two records pushed but packet still open");

   a_pair_ends: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.second.kind == KIND_END && push.second.last)
      else $error("second record of a pair is not an end record");

   a_flush_single: assert property (@(posedge clock) disable iff (reset)
      advance && stage_ff.op |-> push.count != 2'd2)
      else $error("flush produced more than one record");
`endif

endmodule

`default_nettype wire

>>> design/pph_out_queue.sv
// Result record queue: takes up to two records per cycle, hands one per
// cycle to the result channel while it is ready. Depends on pph_pkg.
`default_nettype none

module pph_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  pph_pkg::push_type    push,
   output logic                 space_ok,
   output pph_pkg::result_type  head,
   output logic                 head_valid,
   input  logic                 head_ready
);
   import pph_pkg::*;

   result_type        mem_ff [Q_DEPTH];
   logic [QA_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0]   wr_next;
   logic [QA_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QA_W:0]     count_ff, count_in;
   logic              pop;

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign pop        = head_valid && head_ready;
   assign space_ok   = (count_ff <= (QA_W+1)'(Q_DEPTH - 2));
   assign wr_next    = wr_ptr_ff + QA_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QA_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + QA_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QA_W+1)'(push.count) - (QA_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != '0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= (QA_W+1)'(Q_DEPTH - 2))
      else $error("records pushed into a full queue");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd0 && !pop |=> $stable(count_ff))
      else $error("queue fill changed without push or pop");
`endif

endmodule

`default_nettype wire

>>> design/pes_packet_header_parser_core.sv
// PES packet header parser, top level: channel wiring, parser stage and
// result queue. Depends on pph_pkg, pph_if, pph_parser and pph_out_queue.
//
// Usage:
//   req_bus carries one stream byte per item (op, data, unit_start); op set
//   means flush, which closes an open packet. rsp_bus delivers records:
//   header, payload bytes, end record with status and last set.
//   csr_bus writes accept_private_one; it is always ready and should be
//   written only while no item is in flight.
// Timing:
//   An accepted item is registered in the parser stage, parsed when that stage
//   advances, and its records are written into the result queue, whose head is
//   presented on rsp_bus. One item per cycle is sustained; the
//   parser stage advances whenever the four-entry result queue has at least
//   two free slots, so an item that yields two records (header plus end,
//   last payload byte plus end, close plus error) uses a second slot.
// Reset:
//   Synchronous, active high: no packet open, queue empty,
//   accept_private_one set to 1.
// Stall:
//   When rsp_bus is not ready, records wait in the queue; once it holds
//   more than two, the parser stage holds its item and req_bus.ready drops.
`default_nettype none

module pes_packet_header_parser_core (
   input  logic        clock,
   input  logic        reset,
   pph_req_if.sink     req_bus,
   pph_rsp_if.source   rsp_bus,
   pph_csr_if.sink     csr_bus
);
   import pph_pkg::*;

   req_type     req_item;
   push_type    push;
   logic        space_ok;
   result_type  head;
   logic        head_valid;
   logic        parser_ready;

   assign req_item.op         = req_bus.op;
   assign req_item.data       = req_bus.data;
   assign req_item.unit_start = req_bus.unit_start;
   assign req_bus.ready       = parser_ready;
   assign csr_bus.ready       = 1'b1;

   pph_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_item  (req_item),
      .req_ready (parser_ready),
      .cfg_we    (csr_bus.valid),
      .cfg_data  (csr_bus.accept_private_one),
      .space_ok  (space_ok),
      .push      (push)
   );

   pph_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space_ok   (space_ok),
      .head       (head),
      .head_valid (head_valid),
      .head_ready (rsp_bus.ready)
   );

   assign rsp_bus.valid        = head_valid;
   assign rsp_bus.kind         = head.kind;
   assign rsp_bus.stream_id    = head.stream_id;
   assign rsp_bus.pts          = head.pts;
   assign rsp_bus.dts          = head.dts;
   assign rsp_bus.pts_valid    = head.pts_valid;
   assign rsp_bus.dts_valid    = head.dts_valid;
   assign rsp_bus.align_flag   = head.align_flag;
   assign rsp_bus.size_known   = head.size_known;
   assign rsp_bus.payload_size = head.payload_size;
   assign rsp_bus.payload_byte = head.payload_byte;
   assign rsp_bus.status       = head.status;
   assign rsp_bus.last         = head.last;

endmodule

`default_nettype wire
